/* rtl/wrp_pkg.sv */
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared transaction types for the WAVE stream parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  data_byte;
    logic        last_of_data;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
  } out_item_t;

endpackage

/* rtl/wrp_parser.sv */
// ----------------------------------------------------------------------------
// wrp_parser
// Parse state and single-byte step logic: header check, chunk walk, fmt
// field capture, data pass-through and error reporting.
// ----------------------------------------------------------------------------
module wrp_parser
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  output logic      res_have,
  output out_item_t res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_DATA,
    PH_SKIP,
    PH_PAD,
    PH_ERROR
  } phase_t;

  localparam logic [2:0]  KIND_DATA       = 3'd0;
  localparam logic [2:0]  KIND_FORMAT     = 3'd1;
  localparam logic [2:0]  KIND_BAD_HEADER = 3'd2;
  localparam logic [2:0]  KIND_NOT_PCM    = 3'd3;
  localparam logic [2:0]  KIND_TRUNCATED  = 3'd4;
  localparam logic [2:0]  KIND_FMT_SHORT  = 3'd5;

  localparam logic [31:0] TAG_RIFF  = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE  = 32'h5741_5645;
  localparam logic [31:0] NAME_FMT  = 32'h464D_5420;
  localparam logic [31:0] NAME_DATA = 32'h4441_5441;
  localparam logic [31:0] FMT_MIN   = 32'd16;
  localparam logic [15:0] TAG_PCM   = 16'd1;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7A) begin
      return b - 8'h20;
    end
    return b;
  endfunction

  // idx 0 is the first character on the wire
  function automatic logic [7:0] tag_char(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = tag[31:24];
      2'd1:    c = tag[23:16];
      2'd2:    c = tag[15:8];
      default: c = tag[7:0];
    endcase
    return c;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  logic [31:0] name_r, name_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic        pad_r, pad_nxt;
  logic [4:0]  fofs_r, fofs_nxt;
  logic [15:0] ftag_r, ftag_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] depth_r, depth_nxt;

  always_comb begin
    logic [7:0]  bval;
    logic [7:0]  fb;
    logic        ok;
    logic        is_err;
    logic        trunc;
    logic [2:0]  cpos;
    logic [4:0]  off;

    bval = item.byte_value;
    fb   = fold_case(bval);
    ok   = 1'b1;
    is_err = 1'b0;
    trunc  = 1'b0;
    cpos   = hdr_pos_r[2:0];
    off    = fofs_r;

    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    name_nxt    = name_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    pad_nxt     = pad_r;
    fofs_nxt    = fofs_r;
    ftag_nxt    = ftag_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    depth_nxt   = depth_r;

    res_have = 1'b0;
    res      = '0;
    res.result_kind = KIND_DATA;

    case (phase_r)
      PH_HEADER: begin
        if (hdr_pos_r < 4'd4) begin
          ok = (fb == tag_char(TAG_RIFF, hdr_pos_r[1:0]));
        end else if (hdr_pos_r >= 4'd8 && hdr_pos_r < 4'd12) begin
          ok = (fb == tag_char(TAG_WAVE, hdr_pos_r[1:0]));
        end
        if (!ok) begin
          res_have = 1'b1;
          is_err   = 1'b1;
          res.result_kind = KIND_BAD_HEADER;
          phase_nxt = PH_ERROR;
        end else if (hdr_pos_r >= 4'd11) begin
          phase_nxt   = PH_CHUNK;
          hdr_pos_nxt = '0;
          name_nxt    = '0;
          len_nxt     = '0;
          pad_nxt     = 1'b0;
        end else begin
          hdr_pos_nxt = hdr_pos_r + 4'd1;
          trunc       = 1'b1;
        end
      end

      PH_CHUNK: begin
        if (cpos < 3'd4) begin
          name_nxt = {name_r[23:0], fb};
        end else begin
          len_nxt = len_r | ({24'd0, bval} << {cpos[1:0], 3'b000});
        end
        if (cpos < 3'd7) begin
          hdr_pos_nxt = {1'b0, cpos + 3'd1};
        end else begin
          pad_nxt  = len_nxt[0];
          left_nxt = len_nxt;
          if (name_nxt == NAME_FMT) begin
            if (len_nxt < FMT_MIN) begin
              res_have = 1'b1;
              is_err   = 1'b1;
              res.result_kind = KIND_FMT_SHORT;
              phase_nxt = PH_ERROR;
            end else begin
              phase_nxt = PH_FMT;
              fofs_nxt  = '0;
              ftag_nxt  = '0;
              chan_nxt  = '0;
              rate_nxt  = '0;
              depth_nxt = '0;
            end
          end else if (len_nxt == 32'd0) begin
            // even length, so no pad: straight to the next chunk header
            phase_nxt   = PH_CHUNK;
            hdr_pos_nxt = '0;
            name_nxt    = '0;
            len_nxt     = '0;
            pad_nxt     = 1'b0;
          end else if (name_nxt == NAME_DATA) begin
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end

      PH_FMT: begin
        if (off < 5'd2) begin
          ftag_nxt = ftag_r | ({8'd0, bval} << {off[0], 3'b000});
        end else if (off < 5'd4) begin
          chan_nxt = chan_r | ({8'd0, bval} << {off[0], 3'b000});
        end else if (off < 5'd8) begin
          rate_nxt = rate_r | ({24'd0, bval} << {off[1:0], 3'b000});
        end else if (off >= 5'd14 && off < 5'd16) begin
          depth_nxt = depth_r | ({8'd0, bval} << {off[0], 3'b000});
        end
        if (left_r != 32'd0) begin
          left_nxt = left_r - 32'd1;
        end
        fofs_nxt = off + 5'd1;
        trunc    = (left_nxt != 32'd0);
        if (off >= 5'd15) begin
          res_have = 1'b1;
          if (ftag_nxt != TAG_PCM) begin
            is_err = 1'b1;
            res.result_kind = KIND_NOT_PCM;
            phase_nxt = PH_ERROR;
          end else begin
            res.result_kind     = KIND_FORMAT;
            res.channels        = chan_nxt;
            res.sample_rate     = rate_nxt;
            res.bits_per_sample = depth_nxt;
            if (left_nxt != 32'd0) begin
              phase_nxt = PH_SKIP;
            end else if (pad_r) begin
              phase_nxt = PH_PAD;
            end else begin
              phase_nxt   = PH_CHUNK;
              hdr_pos_nxt = '0;
              name_nxt    = '0;
              len_nxt     = '0;
              pad_nxt     = 1'b0;
            end
          end
        end
      end

      PH_DATA, PH_SKIP: begin
        if (left_r != 32'd0) begin
          left_nxt = left_r - 32'd1;
        end
        if (phase_r == PH_DATA) begin
          res_have = 1'b1;
          res.result_kind  = KIND_DATA;
          res.data_byte    = bval;
          res.last_of_data = (left_nxt == 32'd0);
          trunc            = (left_nxt != 32'd0);
        end
        if (left_nxt == 32'd0) begin
          if (pad_r) begin
            phase_nxt = PH_PAD;
          end else begin
            phase_nxt   = PH_CHUNK;
            hdr_pos_nxt = '0;
            name_nxt    = '0;
            len_nxt     = '0;
            pad_nxt     = 1'b0;
          end
        end
      end

      PH_PAD: begin
        phase_nxt   = PH_CHUNK;
        hdr_pos_nxt = '0;
        name_nxt    = '0;
        len_nxt     = '0;
        pad_nxt     = 1'b0;
      end

      default: begin
      end
    endcase

    // truncation overrides a data/format transaction, never an error
    if (item.end_of_file && trunc && !is_err) begin
      res_have = 1'b1;
      res      = '0;
      res.result_kind = KIND_TRUNCATED;
    end

    if (item.end_of_file) begin
      phase_nxt   = PH_HEADER;
      hdr_pos_nxt = '0;
      name_nxt    = '0;
      len_nxt     = '0;
      left_nxt    = '0;
      pad_nxt     = 1'b0;
      fofs_nxt    = '0;
      ftag_nxt    = '0;
      chan_nxt    = '0;
      rate_nxt    = '0;
      depth_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_pos_r <= '0;
      name_r    <= '0;
      len_r     <= '0;
      left_r    <= '0;
      pad_r     <= 1'b0;
      fofs_r    <= '0;
      ftag_r    <= '0;
      chan_r    <= '0;
      rate_r    <= '0;
      depth_r   <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      name_r    <= name_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      pad_r     <= pad_nxt;
      fofs_r    <= fofs_nxt;
      ftag_r    <= ftag_nxt;
      chan_r    <= chan_nxt;
      rate_r    <= rate_nxt;
      depth_r   <= depth_nxt;
    end
  end

endmodule

/* rtl/wrp_out_stage.sv */
// ----------------------------------------------------------------------------
// wrp_out_stage
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module wrp_out_stage
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= load_data;
    end
  end

endmodule

/* rtl/wave_riff_stream_parser.sv */
// Path: an input transaction is held in the input register, then its result
//   transaction is presented from the result register.
// Throughput: 1 byte per cycle; the only stall is a held result at the output.
// Reset: synchronous, active low; clears the parse state to expect the file
//   header and empties both registers. End of file returns the parse state to
//   the file header after its byte.
// ----------------------------------------------------------------------------
// wave_riff_stream_parser
// Byte-stream RIFF/WAVE PCM parser: format report, data pass-through, errors.
// ----------------------------------------------------------------------------
module wave_riff_stream_parser
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      stg_valid_r;
  in_item_t  stg_data_r;
  logic      stg_adv;
  logic      step_en;
  logic      res_have;
  out_item_t res;
  logic      out_free;

  // a byte with no result never waits on the output side
  assign stg_adv  = !res_have || out_free;
  assign step_en  = stg_valid_r && stg_adv;
  assign in_ready = !stg_valid_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_data_r <= in_data;
    end
  end

  wrp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .item     (stg_data_r),
    .res_have (res_have),
    .res      (res)
  );

  wrp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && res_have),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb_wave_riff_stream_parser.sv */
// ----------------------------------------------------------------------------
// tb_wave_riff_stream_parser
// Self-checking bench for the WAVE stream parser. Byte streams are built as
// whole files: clean PCM files, odd-sized and padded chunks, repeated chunks,
// bad headers, non-PCM and short fmt chunks, cut-off files and raw noise.
// A scoreboard tracks the parse state per accepted byte, predicts each
// result and checks every result transaction in order. Both sides idle at
// random, and once the result side holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_wave_riff_stream_parser;
  import wrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    P_FILE_HDR, P_CHUNK_HDR, P_FMT_BODY, P_DATA_BODY, P_SKIP_BODY, P_PAD, P_FAULT
  } parse_phase_e;

  typedef enum logic [2:0] {
    R_DATA, R_FORMAT, R_BAD_HEADER, R_NOT_PCM, R_TRUNCATED, R_FMT_SHORT
  } result_kind_e;

  localparam logic [31:0] RIFF_TAG  = 32'h52494646;
  localparam logic [31:0] WAVE_TAG  = 32'h57415645;
  localparam logic [31:0] NAME_FMT  = 32'h464D5420;
  localparam logic [31:0] NAME_DATA = 32'h44415441;
  localparam logic [31:0] NAME_LIST = 32'h4C495354;
  localparam logic [31:0] NAME_FACT = 32'h46414354;
  localparam int unsigned PCM_TAG   = 1;
  localparam int unsigned FMT_CORE  = 16;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  wave_riff_stream_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  // --------------------------------------------------------------------------
  // Parse tracker and result checker
  // --------------------------------------------------------------------------
  class wave_parse_scoreboard;
    parse_phase_e phase;
    logic [3:0]   hdr_pos;
    logic [31:0]  name;
    logic [31:0]  length;
    logic [31:0]  left;
    logic         pad;
    logic [4:0]   fmt_off;
    logic [15:0]  tag;
    logic [15:0]  chans;
    logic [31:0]  rate;
    logic [15:0]  depth;
    out_item_t    expected_q[$];
    int unsigned  mismatches;
    int unsigned  accepted;

    function new();
      clear_state();
      mismatches = 0;
      accepted = 0;
    endfunction

    function void clear_state();
      phase = P_FILE_HDR;
      hdr_pos = '0;
      name = '0;
      length = '0;
      left = '0;
      pad = 1'b0;
      fmt_off = '0;
      tag = '0;
      chans = '0;
      rate = '0;
      depth = '0;
    endfunction

    function void open_chunk();
      phase = P_CHUNK_HDR;
      hdr_pos = '0;
      name = '0;
      length = '0;
      pad = 1'b0;
    endfunction

    function void close_body();
      if (pad) phase = P_PAD;
      else open_chunk();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0] b;
      logic [7:0] up;
      logic [2:0] cpos;
      logic [4:0] off;
      logic       ok;
      logic       emit;
      logic       fault;
      logic       trunc;
      out_item_t  res;
      b = it.byte_value;
      up = upcase(b);
      emit = 1'b0;
      fault = 1'b0;
      trunc = 1'b0;
      res = '0;
      accepted++;
      case (phase)
        P_FILE_HDR: begin
          if (hdr_pos < 4) ok = (up == RIFF_TAG[8*(3-hdr_pos) +: 8]);
          else if (hdr_pos >= 8) ok = (up == WAVE_TAG[8*(11-hdr_pos) +: 8]);
          else ok = 1'b1;
          if (!ok) begin
            emit = 1'b1;
            fault = 1'b1;
            res.result_kind = R_BAD_HEADER;
            phase = P_FAULT;
          end else if (hdr_pos >= 11) begin
            open_chunk();
          end else begin
            hdr_pos = hdr_pos + 4'd1;
            trunc = 1'b1;
          end
        end
        P_CHUNK_HDR: begin
          cpos = hdr_pos[2:0];
          if (cpos < 4) name = {name[23:0], up};
          else length[8*(cpos-4) +: 8] = b;
          if (cpos < 7) begin
            hdr_pos = hdr_pos + 4'd1;
          end else begin
            pad = length[0];
            left = length;
            if (name == NAME_FMT) begin
              if (length < FMT_CORE) begin
                emit = 1'b1;
                fault = 1'b1;
                res.result_kind = R_FMT_SHORT;
                phase = P_FAULT;
              end else begin
                phase = P_FMT_BODY;
                fmt_off = '0;
                tag = '0;
                chans = '0;
                rate = '0;
                depth = '0;
              end
            end else if (length == 0) begin
              close_body();
            end else begin
              phase = (name == NAME_DATA) ? P_DATA_BODY : P_SKIP_BODY;
            end
          end
        end
        P_FMT_BODY: begin
          off = fmt_off;
          if (off < 2) tag[8*off +: 8] = b;
          else if (off < 4) chans[8*(off-2) +: 8] = b;
          else if (off < 8) rate[8*(off-4) +: 8] = b;
          else if (off >= 14) depth[8*(off-14) +: 8] = b;
          if (left != 0) left--;
          fmt_off = off + 5'd1;
          trunc = (left != 0);
          if (off == FMT_CORE - 1) begin
            emit = 1'b1;
            if (tag != PCM_TAG) begin
              fault = 1'b1;
              res.result_kind = R_NOT_PCM;
              phase = P_FAULT;
            end else begin
              res.result_kind = R_FORMAT;
              res.channels = chans;
              res.sample_rate = rate;
              res.bits_per_sample = depth;
              // fmt bytes past the core 16 are skipped like any other body
              if (left == 0) close_body();
              else phase = P_SKIP_BODY;
            end
          end
        end
        P_DATA_BODY: begin
          if (left != 0) left--;
          emit = 1'b1;
          res.result_kind = R_DATA;
          res.data_byte = b;
          res.last_of_data = (left == 0);
          trunc = (left != 0);
          if (left == 0) close_body();
        end
        P_SKIP_BODY: begin
          if (left != 0) left--;
          if (left == 0) close_body();
        end
        P_PAD: open_chunk();
        default: ;
      endcase
      // end of file inside a reported body replaces that result, not an error
      if (it.end_of_file && trunc && !fault) begin
        emit = 1'b1;
        res = '0;
        res.result_kind = R_TRUNCATED;
      end
      if (it.end_of_file) clear_state();
      if (emit) expected_q.push_back(res);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      report("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      report("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      report("last_of_data", 32'(want.last_of_data), 32'(got.last_of_data));
      report("channels", 32'(want.channels), 32'(got.channels));
      report("sample_rate", want.sample_rate, got.sample_rate);
      report("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
    endfunction
  endclass

  wave_parse_scoreboard sb;

  // --------------------------------------------------------------------------
  // Stream construction
  // --------------------------------------------------------------------------
  in_item_t    stim_q[$];
  logic [7:0]  file_bytes[$];
  int unsigned hold_left = 0;
  bit          no_idle = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_item(logic [7:0] b, logic eof);
    in_item_t it;
    it.byte_value = b;
    it.end_of_file = eof;
    stim_q.push_back(it);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  // letters go out in random case, the parser folds them
  function automatic void put_tag(logic [31:0] t);
    logic [7:0] c;
    for (int i = 3; i >= 0; i--) begin
      c = t[8*i +: 8];
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) c = c | 8'h20;
      file_bytes.push_back(c);
    end
  endfunction

  function automatic void put_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_chunk(logic [31:0] nm, int unsigned size);
    put_tag(nm);
    put_le(size, 4);
    put_random(size);
    if (size % 2) put_random(1);
  endfunction

  function automatic logic [31:0] other_name();
    case ($urandom_range(0, 2))
      0: return NAME_LIST;
      1: return NAME_FACT;
      default: return $urandom;
    endcase
  endfunction

  function automatic void put_fmt(logic [15:0] fmt_tag, int unsigned size);
    logic [15:0] ch;
    logic [15:0] bits;
    put_tag(NAME_FMT);
    put_le(size, 4);
    if (size < FMT_CORE) begin
      put_random(size);
    end else begin
      case ($urandom_range(0, 2))
        0: ch = 16'd1;
        1: ch = 16'd2;
        default: ch = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: bits = 16'd8;
        1: bits = 16'd16;
        2: bits = 16'd24;
        default: bits = 16'($urandom);
      endcase
      put_le({16'd0, fmt_tag}, 2);
      put_le({16'd0, ch}, 2);
      put_le($urandom, 4);
      put_random(6);
      put_le({16'd0, bits}, 2);
      put_random(size - FMT_CORE);
    end
    if (size % 2) put_random(1);
  endfunction

  function automatic void build_file(int unsigned scen);
    int unsigned cut;
    int unsigned idx;
    logic [15:0] odd_tag;
    logic [7:0]  bad;
    file_bytes.delete();
    if (scen != 8) begin
      put_tag(RIFF_TAG);
      put_le($urandom, 4);
      put_tag(WAVE_TAG);
    end
    case (scen)
      0: begin
        put_fmt(16'(PCM_TAG), FMT_CORE);
        put_chunk(NAME_DATA, $urandom_range(1, 16));
      end
      1, 5: begin
        put_fmt(16'(PCM_TAG), $urandom_range(17, 21));
        put_chunk(other_name(), $urandom_range(1, 5));
        put_chunk(NAME_DATA, 2 * $urandom_range(0, 6) + 1);
      end
      2: begin
        odd_tag = 16'($urandom);
        if (odd_tag == PCM_TAG) odd_tag = 16'h0003;
        put_fmt(odd_tag, FMT_CORE);
        put_chunk(NAME_DATA, 4);
      end
      3: begin
        put_fmt(16'(PCM_TAG), $urandom_range(0, 15));
        put_chunk(NAME_DATA, 3);
      end
      4: begin
        put_fmt(16'(PCM_TAG), FMT_CORE);
        put_chunk(NAME_DATA, 4);
        idx = $urandom_range(0, 7);
        if (idx >= 4) idx = idx + 4;
        bad = 8'($urandom);
        if (upcase(bad) == upcase(file_bytes[idx])) bad = bad ^ 8'h01;
        file_bytes[idx] = bad;
      end
      6: begin
        put_chunk(other_name(), 0);
        put_fmt(16'(PCM_TAG), FMT_CORE);
        put_chunk(NAME_DATA, 0);
        put_chunk(NAME_DATA, $urandom_range(1, 6));
      end
      7: begin
        // huge declared size, file ends long before it
        put_fmt(16'(PCM_TAG), FMT_CORE);
        put_tag($urandom_range(0, 1) ? NAME_DATA : other_name());
        put_le($urandom | 32'h0000_0100, 4);
        put_random($urandom_range(1, 8));
      end
      8: put_random($urandom_range(1, 12));
      default: begin
        put_fmt(16'(PCM_TAG), FMT_CORE);
        put_chunk(NAME_DATA, $urandom_range(1, 5));
        put_fmt(16'(PCM_TAG), FMT_CORE + $urandom_range(0, 3));
        put_chunk(NAME_DATA, $urandom_range(1, 5));
        put_chunk(other_name(), $urandom_range(0, 3));
        put_chunk(NAME_DATA, $urandom_range(1, 4));
      end
    endcase
    cut = file_bytes.size() - 1;
    if (scen == 5) cut = $urandom_range(0, file_bytes.size() - 1);
    for (int unsigned i = 0; i <= cut; i++)
      push_item(file_bytes[i], (i == cut) || (scen == 8 && $urandom_range(0, 9) == 0));
  endfunction

  function automatic void build_stimulus();
    int unsigned n;
    int unsigned r;
    logic [7:0]  lead[12];
    // short directed streams: field extremes and header edge cases
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    push_item("r", 1'b0);
    push_item("I", 1'b0);
    push_item("f", 1'b1);
    push_item("R", 1'b0);
    push_item("Q", 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b1);
    lead = '{"R", "i", "F", "f", 8'hFF, 8'hFF, 8'hFF, 8'hFF, "w", "A", "v", "e"};
    foreach (lead[i]) push_item(lead[i], i == 11);
    // every file shape once, then a random mix led by well-formed files
    n = 0;
    while (stim_q.size() < 600) begin
      if (n < 10) begin
        build_file(n);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          case ($urandom_range(0, 3))
            0: build_file(0);
            1: build_file(1);
            2: build_file(6);
            default: build_file(9);
          endcase
        end
        else if (r < 55) build_file(2);
        else if (r < 62) build_file(3);
        else if (r < 70) build_file(4);
        else if (r < 82) build_file(5);
        else if (r < 90) build_file(7);
        else build_file(8);
      end
      n++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off to back up the input
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    bit          pressure_done;
    stall_left = 0;
    pressure_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (!pressure_done && sb.accepted >= 150) begin
        hold_left = 300;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte side and end of run
  // --------------------------------------------------------------------------
  task automatic send_byte(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(it);
  endtask

  initial begin
    int unsigned gap;
    sb = new();
    build_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stim_q[i]) begin
      no_idle = (i >= 300 && i < 380);
      // keep offering while the result side is held off
      gap = (no_idle || hold_left > 0) ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_byte(stim_q[i]);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
